[hdl/cled_pkg.sv]
package cled_pkg;

	// result kinds
	localparam logic [1:0] KIND_BYTE = 2'd0;
	localparam logic [1:0] KIND_DONE = 2'd1;
	localparam logic [1:0] KIND_ERR  = 2'd2;

	// error codes
	localparam logic [1:0] ERR_NONE    = 2'd0;
	localparam logic [1:0] ERR_NEWLINE = 2'd1;
	localparam logic [1:0] ERR_EMPTY   = 2'd2;
	localparam logic [1:0] ERR_ESCAPE  = 2'd3;

	// source characters with a special role
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_X      = 8'h78;

	localparam logic [15:0] LEN_MAX = 16'hFFFF;

	typedef struct packed {
		logic [1:0]         kind;
		logic signed [31:0] value;
		logic [15:0]        count;
		logic               is_char_const;
		logic [1:0]         err_code;
		logic               last;
	} result_t;

	// all results caused by one accepted character
	typedef struct packed {
		logic    two;
		result_t r0;
		result_t r1;
	} entry_t;

	// queue status seen by the front and the back
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	function automatic result_t mk_res(logic [1:0] kind, logic [31:0] value,
			logic [15:0] count, logic isc, logic [1:0] err);
		result_t r;
		r.kind          = kind;
		r.value         = value;
		r.count         = count;
		r.is_char_const = isc;
		r.err_code      = err;
		r.last          = 1'b0;
		return r;
	endfunction

endpackage

[hdl/cled_ch_if.sv]
interface cled_ch_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;

	modport source (output valid, output ch, input ready);
	modport sink (input valid, input ch, output ready);
endinterface

[hdl/cled_res_if.sv]
interface cled_res_if;
	logic               valid;
	logic               ready;
	logic [1:0]         kind;
	logic signed [31:0] value;
	logic [15:0]        count;
	logic               is_char_const;
	logic [1:0]         err_code;
	logic               last;

	modport source (output valid, output kind, output value, output count,
		output is_char_const, output err_code, output last, input ready);
	modport sink (input valid, input kind, input value, input count,
		input is_char_const, input err_code, input last, output ready);
endinterface

[hdl/cled_front.sv]
module cled_front #(
	parameter int OCTAL_MAX_DIGITS = 3
) (
	input  logic                  clk,
	input  logic                  arst_n,
	cled_ch_if.sink               din,
	input  cled_pkg::q_stat_t     q_stat,
	output logic                  push,
	output cled_pkg::entry_t      push_entry
);

	localparam logic [2:0] PH_IDLE     = 3'd0;
	localparam logic [2:0] PH_BODY     = 3'd1;
	localparam logic [2:0] PH_ESC      = 3'd2;
	localparam logic [2:0] PH_HEXSTART = 3'd3;
	localparam logic [2:0] PH_HEX      = 3'd4;
	localparam logic [2:0] PH_OCT      = 3'd5;

	localparam logic [1:0] OCT_MAX = 2'(OCTAL_MAX_DIGITS);

	logic [2:0]  phase_q;
	logic        char_mode_q;
	logic        first_seen_q;
	logic [31:0] accum_q;
	logic [1:0]  oct_digits_q;
	logic [31:0] const_value_q;
	logic [15:0] len_q;

	logic [2:0]  ph_n;
	logic        cm_n;
	logic        fs_n;
	logic [31:0] acc_n;
	logic [1:0]  od_n;
	logic [31:0] cv_n;
	logic [15:0] len_n;

	logic              a_v;
	logic              b_v;
	cled_pkg::result_t res_a;
	cled_pkg::result_t res_b;
	logic              dlv;
	logic [31:0]       dlv_val;
	logic              body;
	logic              accept;

	// {valid, digit value}
	function automatic logic [4:0] hex_val(logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c inside {[8'h30:8'h39]}) r = {1'b1, 4'(c - 8'h30)};
		else if (c inside {[8'h61:8'h66]}) r = {1'b1, 4'(c - 8'h57)};
		else if (c inside {[8'h41:8'h46]}) r = {1'b1, 4'(c - 8'h37)};
		return r;
	endfunction

	// {valid, escaped byte}
	function automatic logic [8:0] simple_esc(logic [7:0] c);
		logic [8:0] r;
		case (c)
			8'h27: r = {1'b1, 8'h27};
			8'h22: r = {1'b1, 8'h22};
			8'h3F: r = {1'b1, 8'h3F};
			8'h5C: r = {1'b1, 8'h5C};
			8'h61: r = {1'b1, 8'd7};
			8'h62: r = {1'b1, 8'd8};
			8'h66: r = {1'b1, 8'd12};
			8'h6E: r = {1'b1, 8'd10};
			8'h72: r = {1'b1, 8'd13};
			8'h74: r = {1'b1, 8'd9};
			8'h76: r = {1'b1, 8'd11};
			default: r = 9'd0;
		endcase
		return r;
	endfunction

	assign din.ready = !q_stat.full;
	assign accept    = din.valid && din.ready;

	always_comb begin
		logic [4:0]  hv;
		logic [8:0]  sv;
		logic [7:0]  c;
		c     = din.ch;
		ph_n  = phase_q;
		cm_n  = char_mode_q;
		fs_n  = first_seen_q;
		acc_n = accum_q;
		od_n  = oct_digits_q;
		cv_n  = const_value_q;
		len_n = len_q;
		a_v   = 1'b0;
		b_v   = 1'b0;
		res_a = cled_pkg::mk_res(cled_pkg::KIND_BYTE, 32'd0, 16'd0, 1'b0,
			cled_pkg::ERR_NONE);
		res_b   = res_a;
		dlv     = 1'b0;
		dlv_val = 32'd0;
		body    = 1'b0;
		hv      = hex_val(c);
		sv      = simple_esc(c);

		// escape stage
		case (phase_q)
			PH_IDLE: begin
				cm_n  = (c == cled_pkg::CH_SQUOTE);
				fs_n  = 1'b0;
				acc_n = 32'd0;
				od_n  = 2'd0;
				cv_n  = 32'd0;
				len_n = 16'd0;
				ph_n  = PH_BODY;
			end
			PH_BODY: body = 1'b1;
			PH_ESC: begin
				if (c == cled_pkg::CH_X) begin
					ph_n = PH_HEXSTART;
				end else if (c inside {[8'h30:8'h37]}) begin
					acc_n = {29'd0, c[2:0]};
					od_n  = 2'd1;
					if (2'd1 >= OCT_MAX) begin
						dlv     = 1'b1;
						dlv_val = acc_n;
					end else begin
						ph_n = PH_OCT;
					end
				end else if (!sv[8]) begin
					a_v   = 1'b1;
					res_a = cled_pkg::mk_res(cled_pkg::KIND_ERR, 32'd0, 16'd0,
						char_mode_q, cled_pkg::ERR_ESCAPE);
					ph_n  = PH_IDLE;
				end else begin
					dlv     = 1'b1;
					dlv_val = {24'd0, sv[7:0]};
				end
			end
			PH_HEXSTART: begin
				if (!hv[4]) begin
					a_v   = 1'b1;
					res_a = cled_pkg::mk_res(cled_pkg::KIND_ERR, 32'd0, 16'd0,
						char_mode_q, cled_pkg::ERR_ESCAPE);
					ph_n  = PH_IDLE;
				end else begin
					acc_n = {28'd0, hv[3:0]};
					ph_n  = PH_HEX;
				end
			end
			PH_HEX: begin
				if (hv[4]) begin
					acc_n = {accum_q[27:0], hv[3:0]};
				end else begin
					dlv     = 1'b1;
					dlv_val = accum_q;
					body    = 1'b1;
				end
			end
			PH_OCT: begin
				if (c inside {[8'h30:8'h37]}) begin
					acc_n = {accum_q[28:0], c[2:0]};
					od_n  = oct_digits_q + 2'd1;
					if (od_n >= OCT_MAX) begin
						dlv     = 1'b1;
						dlv_val = acc_n;
					end
				end else begin
					dlv     = 1'b1;
					dlv_val = accum_q;
					body    = 1'b1;
				end
			end
			default: ph_n = PH_IDLE;
		endcase

		// hand the escape value to the literal
		if (dlv) begin
			if (cm_n) begin
				if (!fs_n) begin
					cv_n = dlv_val;
					fs_n = 1'b1;
				end
			end else begin
				a_v   = 1'b1;
				res_a = cled_pkg::mk_res(cled_pkg::KIND_BYTE, {24'd0, dlv_val[7:0]},
					16'd0, 1'b0, cled_pkg::ERR_NONE);
				if (len_n < cled_pkg::LEN_MAX) len_n = len_n + 16'd1;
			end
			ph_n = PH_BODY;
		end

		// ordinary body character
		if (body) begin
			if (cm_n && c == cled_pkg::CH_SQUOTE) begin
				b_v = 1'b1;
				if (!fs_n) res_b = cled_pkg::mk_res(cled_pkg::KIND_ERR, 32'd0, 16'd0,
					1'b1, cled_pkg::ERR_EMPTY);
				else res_b = cled_pkg::mk_res(cled_pkg::KIND_DONE, cv_n, 16'd0,
					1'b1, cled_pkg::ERR_NONE);
				ph_n = PH_IDLE;
			end else if (!cm_n && c == cled_pkg::CH_DQUOTE) begin
				b_v   = 1'b1;
				res_b = cled_pkg::mk_res(cled_pkg::KIND_DONE, 32'd0,
					(len_n < cled_pkg::LEN_MAX) ? len_n + 16'd1 : cled_pkg::LEN_MAX,
					1'b0, cled_pkg::ERR_NONE);
				ph_n  = PH_IDLE;
			end else if (c == cled_pkg::CH_BSLASH) begin
				ph_n = PH_ESC;
			end else if (c == cled_pkg::CH_NL) begin
				b_v   = 1'b1;
				res_b = cled_pkg::mk_res(cled_pkg::KIND_ERR, 32'd0, 16'd0, cm_n,
					cled_pkg::ERR_NEWLINE);
				ph_n  = PH_IDLE;
			end else if (cm_n) begin
				if (!fs_n) begin
					cv_n = {24'd0, c};
					fs_n = 1'b1;
				end
				ph_n = PH_BODY;
			end else begin
				b_v   = 1'b1;
				res_b = cled_pkg::mk_res(cled_pkg::KIND_BYTE, {24'd0, c}, 16'd0, 1'b0,
					cled_pkg::ERR_NONE);
				if (len_n < cled_pkg::LEN_MAX) len_n = len_n + 16'd1;
				ph_n  = PH_BODY;
			end
		end
	end

	// pack the results of this character into one queue entry
	always_comb begin
		push_entry.two = a_v && b_v;
		push_entry.r0  = a_v ? res_a : res_b;
		push_entry.r1  = res_b;
		if (a_v && b_v) push_entry.r1.last = 1'b1;
		else push_entry.r0.last = 1'b1;
	end

	assign push = accept && (a_v || b_v);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_IDLE;
			char_mode_q   <= 1'b0;
			first_seen_q  <= 1'b0;
			accum_q       <= 32'd0;
			oct_digits_q  <= 2'd0;
			const_value_q <= 32'd0;
			len_q         <= 16'd0;
		end else if (accept) begin
			phase_q       <= ph_n;
			char_mode_q   <= cm_n;
			first_seen_q  <= fs_n;
			accum_q       <= acc_n;
			oct_digits_q  <= od_n;
			const_value_q <= cv_n;
			len_q         <= len_n;
		end
	end

endmodule

[hdl/cled_queue.sv]
module cled_queue #(
	parameter int DEPTH = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  cled_pkg::entry_t     push_entry,
	input  logic                 pop,
	output cled_pkg::entry_t     head,
	output cled_pkg::q_stat_t    q_stat
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cled_pkg::entry_t mem_q [DEPTH];
	logic [AW-1:0]    wr_q;
	logic [AW-1:0]    rd_q;
	logic [CW-1:0]    cnt_q;

	assign q_stat.full  = (cnt_q == CW'(DEPTH));
	assign q_stat.empty = (cnt_q == '0);
	assign head         = mem_q[rd_q];

	function automatic logic [AW-1:0] bump(logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= bump(wr_q);
			if (pop) rd_q <= bump(rd_q);
			if (push && !pop) cnt_q <= cnt_q + CW'(1);
			else if (pop && !push) cnt_q <= cnt_q - CW'(1);
		end
	end

endmodule

[hdl/cled_back.sv]
module cled_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cled_pkg::entry_t     head,
	input  cled_pkg::q_stat_t    q_stat,
	output logic                 pop,
	cled_res_if.source           dout
);

	logic              idx_q;
	logic              fire;
	cled_pkg::result_t cur;

	assign cur  = idx_q ? head.r1 : head.r0;
	assign fire = dout.valid && dout.ready;
	// drop the entry once its final result is taken
	assign pop  = fire && (idx_q || !head.two);

	assign dout.valid         = !q_stat.empty;
	assign dout.kind          = cur.kind;
	assign dout.value         = cur.value;
	assign dout.count         = cur.count;
	assign dout.is_char_const = cur.is_char_const;
	assign dout.err_code      = cur.err_code;
	assign dout.last          = cur.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= 1'b0;
		end else if (fire) begin
			idx_q <= !pop;
		end
	end

endmodule

[hdl/c_literal_escape_decoder.sv]
// C string literal / character constant escape decoder.
//
// din carries one source character per beat; the first beat of a literal is
// its opening delimiter (single quote: character constant, else string).
// dout carries results: decoded string bytes, a completion beat (string
// length plus one, or the character constant's value) and error beats.
// One character can cause up to two results; last marks the final one.
//
// The front decodes one character per cycle while the queue has room and
// writes all results of that character as one entry into a short queue;
// the back drains it, one result beat per cycle while dout is ready.
// din.ready depends only on queue space, so a new character is taken every
// cycle while the queue has room, also while dout is stalled. The results of
// a character are registered in the queue before they reach dout; one with
// two results takes two dout beats on the single output port. When dout
// stalls, up to QUEUE_DEPTH characters' results are held, then din.ready
// drops. Reset empties the queue and returns the decoder to idle.
module c_literal_escape_decoder #(
	parameter int OCTAL_MAX_DIGITS = 3,
	parameter int QUEUE_DEPTH      = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	cled_ch_if.sink     din,
	cled_res_if.source  dout
);

	cled_pkg::q_stat_t q_stat;
	cled_pkg::entry_t  push_entry;
	cled_pkg::entry_t  head;
	logic              push;
	logic              pop;

	// classify and decode each character
	cled_front #(
		.OCTAL_MAX_DIGITS(OCTAL_MAX_DIGITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.din        (din),
		.q_stat     (q_stat),
		.push       (push),
		.push_entry (push_entry)
	);

	// hold per-character result groups between front and back
	cled_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.q_stat     (q_stat)
	);

	// serialize each group onto dout
	cled_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.q_stat (q_stat),
		.pop    (pop),
		.dout   (dout)
	);

	// a completion or an error always ends the results of its character
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		dout.valid && (dout.kind == cled_pkg::KIND_DONE ||
		dout.kind == cled_pkg::KIND_ERR) |-> dout.last)
		else $error("completion or error beat without last");

	// errors carry a code, other beats none
	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		dout.valid |-> ((dout.kind == cled_pkg::KIND_ERR) ==
		(dout.err_code != cled_pkg::ERR_NONE)))
		else $error("error code does not match result kind");

	// string bytes are zero extended and never flagged as character constant
	a_byte_fmt: assert property (@(posedge clk) disable iff (!arst_n)
		dout.valid && dout.kind == cled_pkg::KIND_BYTE |->
		dout.value[31:8] == 24'd0 && !dout.is_char_const && dout.count == 16'd0)
		else $error("malformed string byte beat");

	// the queue frees space only through a dout beat
	a_ready_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!din.ready && !(dout.valid && dout.ready) |=> !din.ready)
		else $error("input ready rose without a drained result");

endmodule
